// File: design/rffd_pkg.sv
// Shared types and constants for the mesh relay duplicate-suppression filter.
// Used by rffd_cell and relay_forward_filter_dedup; depends on nothing else.
package rffd_pkg;

    // Cache geometry.
    localparam int CACHE_ENTRIES = 8;
    localparam int SLOT_W        = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

    // Field widths.
    localparam int SENDER_W = 24;
    localparam int TIME_W   = 32;
    localparam int TTL_W    = 16;
    localparam int RSSI_W   = 9;
    localparam int JIT_W    = 10;
    localparam int HDR_W    = 8;
    localparam int VEND_W   = 8;
    localparam int ADDR_W   = 16;
    localparam int DEC_W    = 3;

    // Stream and configuration port widths.
    localparam int S_TDATA_W  = 88;
    localparam int M_TDATA_W  = 48;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Protocol constants.
    localparam int                 FWD_BIT    = 6;
    localparam logic [TIME_W-1:0]  BASE_DELAY = 32'd500;
    localparam logic [JIT_W-1:0]   JITTER_MOD = 10'd1000;
    localparam logic [RSSI_W-1:0]  RSSI_RESET = 9'h1A4;   // -92 dBm
    localparam logic [TTL_W-1:0]   TTL_RESET  = 16'd10000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RSSI_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEDUP_TTL      = 1'd1;

    // Result codes.
    typedef enum logic [DEC_W-1:0] {
        DEC_NO_FORWARD = 3'd0,
        DEC_BUSY       = 3'd1,
        DEC_TOO_STRONG = 3'd2,
        DEC_DUPLICATE  = 3'd3,
        DEC_QUEUED     = 3'd4,
        DEC_RELEASED   = 3'd5
    } decision_t;

    // Lookup token that walks the cell chain.
    typedef struct packed {
        logic                valid;
        logic                hit;
        logic [SENDER_W-1:0] sender;
        logic [TIME_W-1:0]   now;
    } tok_t;

    // Broadcast write of one cache entry.
    typedef struct packed {
        logic                en;
        logic [SLOT_W-1:0]   slot;
        logic [SENDER_W-1:0] sender;
        logic [TIME_W-1:0]   stamp;
    } cell_wr_t;

endpackage

// File: design/rffd_cell.sv
// One cache cell: holds a sender id, its time stamp and a valid bit, and
// checks the passing lookup token against them. Depends on rffd_pkg.
module rffd_cell import rffd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [SLOT_W-1:0] cell_idx,
    input  logic [TTL_W-1:0]  ttl,
    input  cell_wr_t          wr,
    input  tok_t              tok_in,
    output tok_t              tok_out
);

    logic                valid_reg;
    logic                valid_next;
    logic [SENDER_W-1:0] sender_reg;
    logic [SENDER_W-1:0] sender_next;
    logic [TIME_W-1:0]   stamp_reg;
    logic [TIME_W-1:0]   stamp_next;
    tok_t                tok_reg;
    tok_t                tok_next;
    logic [TIME_W-1:0]   age;
    logic                match;

    // Entry matches when valid, same sender and wrapping age below the TTL.
    always_comb begin
        age   = tok_in.now - stamp_reg;
        match = valid_reg && (sender_reg == tok_in.sender) &&
                (age < TIME_W'(ttl));
        tok_next     = tok_in;
        tok_next.hit = tok_in.hit | match;
    end

    // Entry update from the broadcast write.
    always_comb begin
        valid_next  = valid_reg;
        sender_next = sender_reg;
        stamp_next  = stamp_reg;
        if (wr.en && (wr.slot == cell_idx)) begin
            valid_next  = 1'b1;
            sender_next = wr.sender;
            stamp_next  = wr.stamp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            tok_reg.valid <= 1'b0;
        end else begin
            valid_reg     <= valid_next;
            tok_reg.valid <= tok_next.valid;
        end
        sender_reg     <= sender_next;
        stamp_reg      <= stamp_next;
        tok_reg.hit    <= tok_next.hit;
        tok_reg.sender <= tok_next.sender;
        tok_reg.now    <= tok_next.now;
    end

    assign tok_out = tok_reg;

endmodule

// File: design/relay_forward_filter_dedup.sv
// Top level of the mesh relay duplicate-suppression filter: request
// handling, relay state and the chain of cache cells. Depends on rffd_pkg
// and rffd_cell.
//
// Each input request yields one result. A release, a header without the
// forward flag, a header arriving while a relay is pending and a header
// that is too strong go from acceptance through the EMIT state to the
// registered result. A relay candidate sends a lookup token down the
// row of CACHE_ENTRIES cache cells, one cell per cycle, and waits in the
// SEARCH state until the token leaves the last cell, so the cell
// chain sets that wait. One request is in work at a time; a new request
// is taken while the previous result still waits on the output register.
// On a miss the sender is written round-robin into the cache and the
// result carries the header byte with the forward flag cleared and the
// send time now + 500 + (jitter mod 1000). Configuration writes are taken
// at any edge and must only be issued while the block is idle.
module relay_forward_filter_dedup import rffd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port.
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Input requests.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // now_ms[31:0], header_byte0[39:32], vendor_id[47:40],
    // node_address[63:48], rssi_dbm[72:64], jitter_ms[82:73], zero[87:83]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // operation[0]
    input  logic [0:0]            s_tuser,
    // Results.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // decision[2:0], relay_byte0[10:3], send_after_ms[42:11], zero[47:43]
    output logic [M_TDATA_W-1:0]  m_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_EMIT   = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [RSSI_W-1:0]   thr_reg, thr_next;
    logic [TTL_W-1:0]    ttl_reg, ttl_next;
    logic                pending_reg, pending_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    decision_t           dec_reg, dec_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [HDR_W-1:0]    hdr_reg, hdr_next;
    logic [SENDER_W-1:0] id_reg, id_next;
    logic [JIT_W-1:0]    jit_reg, jit_next;
    logic                m_valid_reg, m_valid_next;
    decision_t           m_dec_reg, m_dec_next;
    logic [HDR_W-1:0]    m_byte_reg, m_byte_next;
    logic [TIME_W-1:0]   m_send_reg, m_send_next;

    logic                accept;
    logic                out_free;
    logic [TIME_W-1:0]   in_now;
    logic [HDR_W-1:0]    in_hdr;
    logic [VEND_W-1:0]   in_vendor;
    logic [ADDR_W-1:0]   in_addr;
    logic [RSSI_W-1:0]   in_rssi;
    logic [JIT_W-1:0]    in_jit;
    logic                rssi_weak;
    logic [JIT_W-1:0]    jit_red;
    logic [TIME_W-1:0]   send_time;
    logic [HDR_W-1:0]    fwd_mask;
    cell_wr_t            wr;
    tok_t                tok_head;
    tok_t                tok [CACHE_ENTRIES+1];
    logic [CACHE_ENTRIES:0] tok_valid;

    // Input field unpacking.
    assign in_now    = s_tdata[31:0];
    assign in_hdr    = s_tdata[39:32];
    assign in_vendor = s_tdata[47:40];
    assign in_addr   = s_tdata[63:48];
    assign in_rssi   = s_tdata[72:64];
    assign in_jit    = s_tdata[82:73];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign rssi_weak = $signed(in_rssi) < $signed(thr_reg);

    // Send time from the latched request, jitter reduced below 1000.
    always_comb begin
        jit_red   = (jit_reg >= JITTER_MOD) ? (jit_reg - JITTER_MOD) : jit_reg;
        send_time = now_reg + BASE_DELAY + TIME_W'(jit_red);
        fwd_mask  = ~(HDR_W'(1) << FWD_BIT);
    end

    // Token injected into the first cell for a relay candidate.
    always_comb begin
        tok_head.valid  = 1'b0;
        tok_head.hit    = 1'b0;
        tok_head.sender = {in_vendor, in_addr};
        tok_head.now    = in_now;
        if (accept && !s_tuser[0] && in_hdr[FWD_BIT] && !pending_reg && rssi_weak) begin
            tok_head.valid = 1'b1;
        end
    end

    assign tok[0] = tok_head;

    // Request sequencing, relay state and result register.
    always_comb begin
        state_next   = state_reg;
        pending_next = pending_reg;
        slot_next    = slot_reg;
        dec_next     = dec_reg;
        now_next     = now_reg;
        hdr_next     = hdr_reg;
        id_next      = id_reg;
        jit_next     = jit_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_dec_next   = m_dec_reg;
        m_byte_next  = m_byte_reg;
        m_send_next  = m_send_reg;
        wr.en        = 1'b0;
        wr.slot      = slot_reg;
        wr.sender    = id_reg;
        wr.stamp     = now_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    now_next   = in_now;
                    hdr_next   = in_hdr;
                    id_next    = {in_vendor, in_addr};
                    jit_next   = in_jit;
                    state_next = ST_EMIT;
                    if (s_tuser[0]) begin
                        dec_next = DEC_RELEASED;
                    end else if (!in_hdr[FWD_BIT]) begin
                        dec_next = DEC_NO_FORWARD;
                    end else if (pending_reg) begin
                        dec_next = DEC_BUSY;
                    end else if (!rssi_weak) begin
                        dec_next = DEC_TOO_STRONG;
                    end else begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (tok[CACHE_ENTRIES].valid) begin
                    dec_next   = tok[CACHE_ENTRIES].hit ? DEC_DUPLICATE : DEC_QUEUED;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_dec_next   = dec_reg;
                    m_byte_next  = '0;
                    m_send_next  = '0;
                    state_next   = ST_IDLE;
                    if (dec_reg == DEC_RELEASED) begin
                        pending_next = 1'b0;
                    end
                    if (dec_reg == DEC_QUEUED) begin
                        wr.en        = 1'b1;
                        pending_next = 1'b1;
                        slot_next    = (slot_reg == SLOT_W'(CACHE_ENTRIES - 1)) ?
                                       '0 : slot_reg + SLOT_W'(1);
                        m_byte_next  = hdr_reg & fwd_mask;
                        m_send_next  = send_time;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration registers.
    always_comb begin
        thr_next = thr_reg;
        ttl_next = ttl_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_RSSI_THRESHOLD: thr_next = cfg_wdata[RSSI_W-1:0];
                CFG_DEDUP_TTL:      ttl_next = cfg_wdata[TTL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            thr_reg     <= RSSI_RESET;
            ttl_reg     <= TTL_RESET;
            pending_reg <= 1'b0;
            slot_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            thr_reg     <= thr_next;
            ttl_reg     <= ttl_next;
            pending_reg <= pending_next;
            slot_reg    <= slot_next;
            m_valid_reg <= m_valid_next;
        end
        dec_reg    <= dec_next;
        now_reg    <= now_next;
        hdr_reg    <= hdr_next;
        id_reg     <= id_next;
        jit_reg    <= jit_next;
        m_dec_reg  <= m_dec_next;
        m_byte_reg <= m_byte_next;
        m_send_reg <= m_send_next;
    end

    // Row of cache cells; the lookup token moves one cell per cycle.
    for (genvar i = 0; i < CACHE_ENTRIES; i++) begin : g_cell
        rffd_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (SLOT_W'(i)),
            .ttl      (ttl_reg),
            .wr       (wr),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1])
        );
    end

    for (genvar i = 0; i <= CACHE_ENTRIES; i++) begin : g_tokv
        assign tok_valid[i] = tok[i].valid;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_send_reg, m_byte_reg, m_dec_reg};

`ifndef SYNTHESIS
    // Only one lookup is ever in flight along the chain.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_valid))
        else $error("more than one lookup token in the cell chain");

    // A token leaves the chain only while a lookup is being waited on.
    assert property (@(posedge aclk) disable iff (!aresetn)
        tok[CACHE_ENTRIES].valid |-> (state_reg == ST_SEARCH))
        else $error("lookup token left the chain outside a search");

    // A relay becomes pending only together with a queued result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(pending_reg) |-> (m_tvalid && (m_tdata[2:0] == DEC_QUEUED)))
        else $error("relay pending without a queued result");

    // The insert slot stays inside the cache.
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(slot_reg) < CACHE_ENTRIES)
        else $error("insert slot out of range");
`endif

endmodule

// File: bench/relay_decision_check.sv
// Checker for the mesh relay duplicate-suppression filter: watches the configuration,
// request and result ports, predicts every relay decision and compares it with the block.
// Depends on rffd_pkg.
module relay_decision_check import rffd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // now_ms[31:0], header_byte0[39:32], vendor_id[47:40],
    // node_address[63:48], rssi_dbm[72:64], jitter_ms[82:73], zero[87:83]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // operation[0]
    input  logic [0:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // decision[2:0], relay_byte0[10:3], send_after_ms[42:11], zero[47:43]
    input  logic [M_TDATA_W-1:0]  m_tdata,
    output int                    mismatches,
    output int                    awaited
);

    typedef struct packed {
        decision_t         decision;
        logic [HDR_W-1:0]  relay_byte;
        logic [TIME_W-1:0] send_after;
    } relay_verdict_t;

    // Shadow copy of the sender cache, relay state and registers.
    logic [SENDER_W-1:0]      seen_sender [CACHE_ENTRIES];
    logic [TIME_W-1:0]        seen_stamp  [CACHE_ENTRIES];
    logic                     seen_valid  [CACHE_ENTRIES];
    int                       next_slot;
    logic                     relay_busy;
    logic signed [RSSI_W-1:0] rssi_limit;
    logic [TTL_W-1:0]         ttl_ms;
    relay_verdict_t           awaited_verdicts [$];
    int                       fail_total = 0;

    // Works out the decision for one request and updates the shadow state.
    function automatic relay_verdict_t decide_relay(input logic release_op,
                                                    input logic [S_TDATA_W-1:0] req);
        logic [TIME_W-1:0]        now;
        logic [HDR_W-1:0]         hdr;
        logic [SENDER_W-1:0]      sender;
        logic signed [RSSI_W-1:0] rssi;
        logic [JIT_W-1:0]         jitter;
        logic [TIME_W-1:0]        age;
        logic                     recent;
        relay_verdict_t           v;
        int                       i;
        now    = req[31:0];
        hdr    = req[39:32];
        sender = {req[47:40], req[63:48]};
        rssi   = req[72:64];
        jitter = req[82:73];
        v      = '{decision: DEC_NO_FORWARD, relay_byte: '0, send_after: '0};
        recent = 1'b0;
        if (release_op) begin
            relay_busy = 1'b0;
            v.decision = DEC_RELEASED;
        end else if (!hdr[FWD_BIT]) begin
            v.decision = DEC_NO_FORWARD;
        end else if (relay_busy) begin
            v.decision = DEC_BUSY;
        end else if (!(rssi < rssi_limit)) begin
            v.decision = DEC_TOO_STRONG;
        end else begin
            // An entry suppresses the sender only while its wrapping age is under the TTL.
            for (i = 0; i < CACHE_ENTRIES; i++) begin
                age = now - seen_stamp[i];
                if (seen_valid[i] && seen_sender[i] == sender && age < TIME_W'(ttl_ms)) begin
                    recent = 1'b1;
                end
            end
            if (recent) begin
                v.decision = DEC_DUPLICATE;
            end else begin
                seen_sender[next_slot] = sender;
                seen_stamp[next_slot]  = now;
                seen_valid[next_slot]  = 1'b1;
                next_slot  = (next_slot + 1) % CACHE_ENTRIES;
                relay_busy = 1'b1;
                v.decision   = DEC_QUEUED;
                v.relay_byte = hdr & ~(HDR_W'(1) << FWD_BIT);
                v.send_after = now + BASE_DELAY + TIME_W'(jitter % JITTER_MOD);
            end
        end
        return v;
    endfunction

    // Follow register writes, compare results and queue predictions.
    always @(posedge aclk) begin : watch
        relay_verdict_t   want;
        logic [DEC_W-1:0] got_decision;
        logic [HDR_W-1:0] got_byte;
        logic [TIME_W-1:0] got_send;
        int               i;
        if (!aresetn) begin
            for (i = 0; i < CACHE_ENTRIES; i++) begin
                seen_sender[i] = '0;
                seen_stamp[i]  = '0;
                seen_valid[i]  = 1'b0;
            end
            next_slot  = 0;
            relay_busy = 1'b0;
            rssi_limit = RSSI_RESET;
            ttl_ms     = TTL_RESET;
            awaited_verdicts.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_RSSI_THRESHOLD: rssi_limit = cfg_wdata[RSSI_W-1:0];
                    CFG_DEDUP_TTL:      ttl_ms = cfg_wdata[TTL_W-1:0];
                    default: ;
                endcase
            end
            // A result always belongs to an earlier request, so compare before queueing.
            if (m_tvalid && m_tready) begin
                got_decision = m_tdata[2:0];
                got_byte     = m_tdata[10:3];
                got_send     = m_tdata[42:11];
                if (awaited_verdicts.size() == 0) begin
                    $display("%0t: result with none expected: decision %0d, byte %02h, send %08h",
                             $time, got_decision, got_byte, got_send);
                    fail_total++;
                end else begin
                    want = awaited_verdicts.pop_front();
                    if (got_decision !== want.decision) begin
                        $display("%0t: decision expected %0d, actual %0d",
                                 $time, want.decision, got_decision);
                        fail_total++;
                    end
                    if (got_byte !== want.relay_byte) begin
                        $display("%0t: relay_byte0 expected %02h, actual %02h",
                                 $time, want.relay_byte, got_byte);
                        fail_total++;
                    end
                    if (got_send !== want.send_after) begin
                        $display("%0t: send_after_ms expected %08h, actual %08h",
                                 $time, want.send_after, got_send);
                        fail_total++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                awaited_verdicts.push_back(decide_relay(s_tuser[0], s_tdata));
            end
        end
        mismatches <= fail_total;
        awaited    <= awaited_verdicts.size();
    end

endmodule

// File: bench/relay_forward_filter_dedup_tb.sv
// Testbench top for the mesh relay duplicate-suppression filter: clock, reset,
// request and result traffic, register phases and the verdict.
// Depends on rffd_pkg, relay_forward_filter_dedup and relay_decision_check.
module relay_forward_filter_dedup_tb;
    import rffd_pkg::*;

    localparam int HOLD_CYCLES = 60;
    localparam int IDLE_LIMIT  = 1000;
    localparam int PHASE_ITEMS = 240;
    localparam int SENDER_POOL = 12;

    typedef struct packed {
        logic              release_op;
        logic [TIME_W-1:0] now;
        logic [HDR_W-1:0]  hdr;
        logic [VEND_W-1:0] vendor;
        logic [ADDR_W-1:0] addr;
        logic [RSSI_W-1:0] rssi;
        logic [JIT_W-1:0]  jitter;
    } request_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    int                    mismatches;
    int                    awaited;

    // Stimulus shaping; burst is shared by the sender and the receiver.
    logic                  burst = 1'b0;
    int                    idle_cycles = 0;
    logic [TIME_W-1:0]     now_cursor = '0;
    int                    step_max = 0;
    int                    rssi_bound = -92;
    logic [SENDER_W-1:0]   sender_pool [SENDER_POOL];

    relay_forward_filter_dedup dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    relay_decision_check check_u (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Ends the run when neither channel moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
            $display("** relay_forward_filter_dedup: FAILED **");
            $finish;
        end
    end

    // Result side: random stalls, two long hold-offs that back the block up.
    initial begin : result_sink
        int stall;
        int taken;
        taken = 0;
        @(posedge aresetn);
        forever begin
            if (taken == 150 || taken == 900) begin
                stall = HOLD_CYCLES;
            end else if (burst) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 6);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do begin
                @(posedge aclk);
            end while (!m_tvalid);
            taken++;
            @(negedge aclk);
        end
    end

    function automatic request_t header_req(input logic release_op, input logic [31:0] now,
                                            input logic [7:0] hdr, input logic [23:0] sender,
                                            input int rssi, input int jitter);
        request_t r;
        r.release_op = release_op;
        r.now        = now;
        r.hdr        = hdr;
        {r.vendor, r.addr} = sender;
        r.rssi       = RSSI_W'(rssi);
        r.jitter     = JIT_W'(jitter);
        return r;
    endfunction

    // Offers one request after a random gap and returns at the negedge after acceptance.
    task automatic send_request(input request_t r);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.release_op;
        s_tdata  <= {5'b0, r.jitter, r.rssi, r.addr, r.vendor, r.hdr, r.now};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Stops offering requests and waits until every result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (awaited != 0) @(negedge aclk);
    endtask

    // Mostly well-formed headers from a small sender pool on a moving clock,
    // with releases mixed in and some noise.
    task automatic make_random(output request_t r);
        int pick;
        int lo;
        int hi;
        r.release_op = ($urandom_range(0, 99) < 30);
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            now_cursor = $urandom;
        end else if (pick < 6) begin
            now_cursor = now_cursor - $urandom_range(0, 5000);
        end else begin
            now_cursor = now_cursor + $urandom_range(0, step_max);
        end
        r.now = now_cursor;
        r.hdr = $urandom;
        if ($urandom_range(0, 99) < 85) r.hdr[FWD_BIT] = 1'b1;
        if ($urandom_range(0, 9) == 0) begin
            {r.vendor, r.addr} = SENDER_W'($urandom);
        end else begin
            {r.vendor, r.addr} = sender_pool[$urandom_range(0, SENDER_POOL - 1)];
        end
        // Aim just under the threshold most of the time so candidates reach the cache.
        hi = rssi_bound - 1;
        lo = (rssi_bound - 41 < -256) ? -256 : rssi_bound - 41;
        if (hi >= -256 && $urandom_range(0, 99) < 80) begin
            r.rssi = RSSI_W'(int'($urandom_range(lo + 256, hi + 256)) - 256);
        end else begin
            r.rssi = $urandom;
        end
        r.jitter = $urandom;
    endtask

    // One register setting followed by a stretch of random requests.
    task automatic run_phase(input int thr, input int ttl, input int step,
                             input logic [TIME_W-1:0] start);
        request_t r;
        int       n;
        drain();
        write_reg(CFG_RSSI_THRESHOLD, {7'($urandom), RSSI_W'(thr)});
        write_reg(CFG_DEDUP_TTL, TTL_W'(ttl));
        rssi_bound = thr;
        step_max   = step;
        now_cursor = start;
        for (n = 0; n < PHASE_ITEMS; n++) begin
            burst = (n >= 100 && n < 140);
            make_random(r);
            send_request(r);
        end
        burst = 1'b0;
    endtask

    initial begin : stimulus
        int i;
        sender_pool[0] = '0;
        sender_pool[1] = '1;
        for (i = 2; i < SENDER_POOL; i++) sender_pool[i] = SENDER_W'($urandom);
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed requests under the reset register values.
        send_request(header_req(1'b0, 32'd0, 8'h00, 24'h000000, -93, 0));
        send_request(header_req(1'b0, 32'd1, 8'hBF, 24'h000000, -93, 0));
        // Sender zero is not suppressed by empty cache entries.
        send_request(header_req(1'b0, 32'd2, 8'h40, 24'h000000, -93, 0));
        send_request(header_req(1'b0, 32'd3, 8'hFF, 24'h000005, -150, 0));
        send_request(header_req(1'b1, 32'd4, 8'h00, 24'h000000, 0, 0));
        // Release with nothing pending.
        send_request(header_req(1'b1, 32'd5, 8'h00, 24'h000000, 0, 0));
        send_request(header_req(1'b0, 32'd100, 8'h40, 24'h000000, -100, 0));
        // RSSI equal to the threshold, then the strongest possible value.
        send_request(header_req(1'b0, 32'd101, 8'h40, 24'h000007, -92, 0));
        send_request(header_req(1'b0, 32'd102, 8'h40, 24'h000007, 255, 0));
        // Send time wraps past the top of the clock; jitter above 999.
        send_request(header_req(1'b0, 32'hFFFF_FFFF, 8'hFF, 24'hFFFFFF, -256, 1023));
        send_request(header_req(1'b1, 32'd0, 8'hFF, 24'hFFFFFF, 0, 0));
        // Age just inside and exactly at the TTL across the clock wrap.
        send_request(header_req(1'b0, 32'd9998, 8'hC0, 24'hFFFFFF, -100, 0));
        send_request(header_req(1'b0, 32'd9999, 8'hC0, 24'hFFFFFF, -100, 999));
        send_request(header_req(1'b1, 32'd9999, 8'h00, 24'h000000, 0, 0));
        send_request(header_req(1'b0, 32'd10000, 8'h7F, 24'h123456, -160, 1000));
        send_request(header_req(1'b1, 32'd10001, 8'h00, 24'h000000, 0, 0));

        // Register settings, extremes included; zero TTL disables suppression.
        run_phase(-92, 10000, 1500, 32'd0);
        run_phase(0, 0, 1000, $urandom);
        run_phase(-160, 65535, 9000, 32'hFFFF_0000);
        run_phase(255, 1, 3, 32'hFFFF_FFF0);
        run_phase(-256, 300, 60, 32'd0);
        run_phase(-60, 4000, 700, $urandom);
        run_phase(-1, 12000, 2000, 32'h7FFF_F000);

        drain();
        repeat (CACHE_ENTRIES + 4) @(negedge aclk);
        if (mismatches == 0 && awaited == 0) begin
            $display("** relay_forward_filter_dedup: PASSED **");
        end else begin
            $display("** relay_forward_filter_dedup: FAILED **");
        end
        $finish;
    end

endmodule
